@@ hdl/fbpa_pkg.sv @@
// shared widths, codes and register indexes of the block pool allocator
`default_nettype none
package fbpa_pkg;

   localparam int BLK_W   = 10;
   localparam int NODES_W = 7;
   localparam int LIMIT_W = 5;
   localparam int STAT_W  = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;

   typedef logic [BLK_W-1:0]   blk_type;
   typedef logic [NODES_W-1:0] nodes_type;
   typedef logic [LIMIT_W-1:0] limit_type;
   typedef logic [STAT_W-1:0]  stat_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam stat_type STAT_OK       = 2'd0;
   localparam stat_type STAT_OOM      = 2'd1;
   localparam stat_type STAT_BAD_FREE = 2'd2;

   localparam csr_idx_type CSR_CHUNK_NODES = 1'd0;
   localparam csr_idx_type CSR_CHUNK_LIMIT = 1'd1;

   localparam nodes_type CHUNK_NODES_RST = 7'd64;
   localparam limit_type CHUNK_LIMIT_RST = 5'd16;

endpackage
`default_nettype wire

@@ hdl/fixed_block_pool_allocator_core.sv @@
// fixed-size block pool allocator: free-list stack in a link memory plus chunk carving
`default_nettype none
// Every request (allocate or free) has an accept step and an execute step: the
// accept step reads the free-list head's link from the synchronous link memory
// and starts splitting the freed block number into chunk and slot; the execute
// step decides, updates the list head or the carve counters, writes the link of
// a freed block and loads the response register. One request is in work at a
// time; a new request is taken as soon as the previous one has moved into the
// response register, so a stalled response holds up at most the next request's
// execute step. The link memory needs no clearing pass: only blocks that were
// pushed by a free are ever popped. Registers are to be written through the
// csr port only while the block is idle; the block does not enforce this.
// chunk_nodes clamps to 1..min(NODES,127) and chunk_limit to 1..min(CHUNKS,31).
module fixed_block_pool_allocator_core #(
   parameter int NODES  = 64,
   parameter int CHUNKS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire logic                  req_opcode,
   input  wire fbpa_pkg::blk_type     req_free_block,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      fbpa_pkg::blk_type     rsp_given_block,
   output      fbpa_pkg::stat_type    rsp_status,
   output      fbpa_pkg::limit_type   rsp_chunks_in_use,
   input  wire logic                  csr_wen,
   input  wire fbpa_pkg::csr_idx_type csr_index,
   input  wire fbpa_pkg::csr_data_type csr_wdata
);
   import fbpa_pkg::*;

   localparam int MEM_DEPTH = 1 << BLK_W;
   localparam int SHIFT     = 2 * BLK_W;
   localparam int RECIP_W   = SHIFT + 1;
   localparam int NODE_W    = $clog2(NODES + 1);
   localparam int REM_W     = BLK_W + NODE_W + 1;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << SHIFT) / NODES);
   localparam logic [REM_W-1:0]   NODES_R = REM_W'(NODES);
   localparam nodes_type NODE_CAP  = NODES_W'((NODES > 127) ? 127 : NODES);
   localparam limit_type LIMIT_CAP = LIMIT_W'((CHUNKS > 31) ? 31 : CHUNKS);
   localparam blk_type   NODES_MOD = BLK_W'(NODES % MEM_DEPTH);

   typedef enum logic {S_IDLE, S_EXEC} state_type;

   state_type state_ff;
   logic      opcode_ff;
   blk_type   blk_ff;
   blk_type   quot_ff;
   nodes_type chunk_nodes_ff;
   limit_type chunk_limit_ff;
   logic      nonempty_ff, nonempty_in;
   blk_type   top_ff, top_in;
   limit_type open_ff, open_in;
   nodes_type carve_ff, carve_in;
   blk_type   base_ff, base_in;
   logic      rsp_valid_ff;
   blk_type   rsp_given_ff, given_in;
   stat_type  rsp_status_ff, status_in;
   limit_type rsp_chunks_ff;

   logic [BLK_W:0] link_mem [MEM_DEPTH];
   logic [BLK_W:0] link_rd_ff;

   logic                      accept;
   logic                      commit;
   logic                      mem_wr;
   logic [BLK_W+RECIP_W-1:0]  prod;
   logic [REM_W-1:0]          qn;
   logic [REM_W-1:0]          rem_raw;
   logic [REM_W-1:0]          slot;
   logic [BLK_W:0]            chunk;
   nodes_type                 eff_nodes;
   limit_type                 eff_limit;
   logic                      bad_free;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign commit    = (state_ff == S_EXEC) && (!rsp_valid_ff || !rsp_stall);

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_given_block   = rsp_given_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_chunks_in_use = rsp_chunks_ff;

   assign eff_nodes = (chunk_nodes_ff == '0) ? NODES_W'(1) :
                      ((chunk_nodes_ff > NODE_CAP) ? NODE_CAP : chunk_nodes_ff);
   assign eff_limit = (chunk_limit_ff == '0) ? LIMIT_W'(1) :
                      ((chunk_limit_ff > LIMIT_CAP) ? LIMIT_CAP : chunk_limit_ff);

   // quotient estimate by reciprocal, low by at most one
   assign prod = BLK_W'(req_free_block) * RECIP;

   // remainder correction against the registered estimate
   always_comb begin
      qn      = REM_W'(quot_ff) * NODES_R;
      rem_raw = REM_W'(blk_ff) - qn;
      if (rem_raw >= NODES_R) begin
         slot  = rem_raw - NODES_R;
         chunk = (BLK_W+1)'(quot_ff) + (BLK_W+1)'(1);
      end else begin
         slot  = rem_raw;
         chunk = (BLK_W+1)'(quot_ff);
      end
      bad_free = (chunk >= (BLK_W+1)'(open_ff)) || (slot >= REM_W'(eff_nodes));
   end

   always_comb begin
      nonempty_in = nonempty_ff;
      top_in      = top_ff;
      open_in     = open_ff;
      carve_in    = carve_ff;
      base_in     = base_ff;
      given_in    = '0;
      status_in   = STAT_OK;
      mem_wr      = 1'b0;
      if (opcode_ff == OP_ALLOC) begin
         if (nonempty_ff) begin
            given_in    = top_ff;
            top_in      = link_rd_ff[BLK_W-1:0];
            nonempty_in = link_rd_ff[BLK_W];
         end else if (carve_ff < eff_nodes) begin
            given_in = base_ff + BLK_W'(carve_ff);
            carve_in = carve_ff + NODES_W'(1);
         end else if (open_ff < eff_limit) begin
            open_in  = open_ff + LIMIT_W'(1);
            base_in  = base_ff + NODES_MOD;
            given_in = base_ff + NODES_MOD;
            carve_in = NODES_W'(1);
         end else begin
            status_in = STAT_OOM;
         end
      end else begin
         if (bad_free) begin
            status_in = STAT_BAD_FREE;
         end else begin
            mem_wr      = 1'b1;
            top_in      = blk_ff;
            nonempty_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         link_rd_ff <= link_mem[top_ff];
      end
      if (commit && mem_wr) begin
         link_mem[blk_ff] <= {nonempty_ff, top_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         chunk_nodes_ff <= CHUNK_NODES_RST;
         chunk_limit_ff <= CHUNK_LIMIT_RST;
         nonempty_ff    <= 1'b0;
         top_ff         <= '0;
         open_ff        <= LIMIT_W'(1);
         carve_ff       <= '0;
         base_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               CSR_CHUNK_NODES: chunk_nodes_ff <= csr_wdata[NODES_W-1:0];
               CSR_CHUNK_LIMIT: chunk_limit_ff <= csr_wdata[LIMIT_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && !rsp_stall && !commit) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  opcode_ff <= req_opcode;
                  blk_ff    <= req_free_block;
                  quot_ff   <= prod[SHIFT +: BLK_W];
                  state_ff  <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (commit) begin
                  nonempty_ff   <= nonempty_in;
                  top_ff        <= top_in;
                  open_ff       <= open_in;
                  carve_ff      <= carve_in;
                  base_ff       <= base_in;
                  rsp_valid_ff  <= 1'b1;
                  rsp_given_ff  <= given_in;
                  rsp_status_ff <= status_in;
                  rsp_chunks_ff <= open_in;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

@@ hdl/fbpa_checker.sv @@
// port-level checks of the block pool allocator and their bind
`default_nettype none
module fbpa_checker (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_stall,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire fbpa_pkg::blk_type   rsp_given_block,
   input wire fbpa_pkg::stat_type  rsp_status,
   input wire fbpa_pkg::limit_type rsp_chunks_in_use
);
   import fbpa_pkg::*;

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_given_block)
         && $stable(rsp_status) && $stable(rsp_chunks_in_use))
      else $error("stalled response changed");

   // no response beat straight out of reset
   a_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // failed requests hand out no block
   a_given_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |-> rsp_given_block == '0)
      else $error("block given on failed request");

   // first chunk is open from reset, so the chunk count is never zero; status is a defined code
   a_chunks_open: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_chunks_in_use != '0 && rsp_status <= STAT_BAD_FREE)
      else $error("bad chunk count or status code");

   // a request is never taken while the previous one is still in its execute step
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken back to back");

endmodule

bind fixed_block_pool_allocator_core fbpa_checker u_fbpa_checker (.*);
`default_nettype wire
